// ----- hdl/manning_flow_velocity_macros.svh -----
// ----------------------------------------------------------------------------
// Manning flow velocity assertion macros
// Concurrent assertion wrappers, clocked on clk; compiled out by NO_ASSERTIONS.
// ----------------------------------------------------------------------------
`ifndef MANNING_FLOW_VELOCITY_MACROS_SVH
`define MANNING_FLOW_VELOCITY_MACROS_SVH

`ifndef NO_ASSERTIONS
// check outside reset
`define MFV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// check on every edge, reset included
`define MFV_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define MFV_ASSERT(lbl, prop, msg)
`define MFV_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

// ----- hdl/mfv_pkg.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity package
// Field widths, unit constants, status and regime codes, pipeline depth.
// ----------------------------------------------------------------------------
package mfv_pkg;

  localparam int N_W    = 16;
  localparam int R_W    = 24;
  localparam int S_W    = 24;
  localparam int A_W    = 24;
  localparam int D_W    = 24;
  localparam int K_W    = 17;
  localparam int G_W    = 22;
  localparam int SQS_W  = 24;
  localparam int R23_W  = 22;
  localparam int SQGD_W = 31;
  localparam int VF_W   = 39;

  localparam int IN_TDATA_W  = 112;
  localparam int OUT_TDATA_W = 112;
  localparam int OUT_TUSER_W = 4;

  // k and g in Q.16
  localparam logic [K_W-1:0] K_SI = 17'd65536;
  localparam logic [K_W-1:0] K_US = 17'd97386;
  localparam logic [G_W-1:0] G_SI = 22'd642908;
  localparam logic [G_W-1:0] G_US = 22'd2108555;

  // register stages from input transaction to the result register
  localparam int LAT = 102;

  typedef enum logic [1:0] {
    ST_OK,
    ST_N_ZERO,
    ST_R_ZERO,
    ST_S_ZERO
  } status_t;

  typedef enum logic [1:0] {
    REG_SUB,
    REG_CRIT,
    REG_SUPER
  } regime_t;

endpackage

// ----- hdl/mfv_delay.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity delay line
// Fixed-depth shift line that keeps side data aligned with the arithmetic.
// ----------------------------------------------------------------------------
module mfv_delay #(
  parameter int W     = 8,
  parameter int DEPTH = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] sr [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      sr[0] <= din;
      for (int i = 1; i < DEPTH; i++) begin
        sr[i] <= sr[i-1];
      end
    end
  end

  assign dout = sr[DEPTH-1];

endmodule

// ----- hdl/mfv_isqrt.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity square root
// Pipelined digit-by-digit integer square root, one result bit per stage.
// ----------------------------------------------------------------------------
module mfv_isqrt #(
  parameter int XW = 48,
  parameter int YW = 24
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [YW-1:0] y
);

  // rem holds x - root^2
  logic [XW-1:0] rem  [YW];
  logic [YW-1:0] root [YW];

  for (genvar i = 0; i < YW; i++) begin : g_step
    localparam int B = YW - 1 - i;
    logic [XW-1:0] rem_in;
    logic [YW-1:0] root_in;
    logic [XW+1:0] delta;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
    end else begin : g_next
      assign rem_in  = rem[i-1];
      assign root_in = root[i-1];
    end

    // (root + 2^B)^2 - root^2
    assign delta = ((XW+2)'(root_in) << (B + 1)) | ((XW+2)'(1) << (2 * B));
    assign take  = ((XW+2)'(rem_in) >= delta);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= take ? rem_in - delta[XW-1:0] : rem_in;
        root[i] <= take ? (root_in | (YW'(1) << B)) : root_in;
      end
    end
  end

  assign y = root[YW-1];

endmodule

// ----- hdl/mfv_icbrt.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity cube root
// Pipelined digit-by-digit integer cube root, one result bit per stage.
// ----------------------------------------------------------------------------
module mfv_icbrt #(
  parameter int XW = 64,
  parameter int YW = 22
) (
  input  logic          clk,
  input  logic          en,
  input  logic [XW-1:0] x,
  output logic [YW-1:0] y
);

  localparam int DW  = 3 * YW + 2;
  localparam int SQW = 2 * YW;

  // rem holds x - root^3, sq holds root^2
  logic [XW-1:0]  rem  [YW];
  logic [YW-1:0]  root [YW];
  logic [SQW-1:0] sq   [YW];

  for (genvar i = 0; i < YW; i++) begin : g_step
    localparam int B = YW - 1 - i;
    logic [XW-1:0]  rem_in;
    logic [YW-1:0]  root_in;
    logic [SQW-1:0] sq_in;
    logic [DW-1:0]  sq3;
    logic [DW-1:0]  root3;
    logic [DW-1:0]  delta;
    logic           take;

    if (i == 0) begin : g_first
      assign rem_in  = x;
      assign root_in = '0;
      assign sq_in   = '0;
    end else begin : g_next
      assign rem_in  = rem[i-1];
      assign root_in = root[i-1];
      assign sq_in   = sq[i-1];
    end

    // (root + 2^B)^3 - root^3 = 3 root^2 2^B + 3 root 2^2B + 2^3B
    assign sq3   = (DW'(sq_in) << 1) + DW'(sq_in);
    assign root3 = (DW'(root_in) << 1) + DW'(root_in);
    assign delta = (sq3 << B) + (root3 << (2 * B)) + (DW'(1) << (3 * B));
    assign take  = (DW'(rem_in) >= delta);

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i]  <= take ? rem_in - delta[XW-1:0] : rem_in;
        root[i] <= take ? (root_in | (YW'(1) << B)) : root_in;
        sq[i]   <= take ? sq_in + (SQW'(root_in) << (B + 1)) + (SQW'(1) << (2 * B))
                        : sq_in;
      end
    end
  end

  assign y = root[YW-1];

endmodule

// ----- hdl/mfv_div.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity divider
// Pipelined restoring divider, one quotient bit per stage; the starting
// remainder must be below the divisor.
// ----------------------------------------------------------------------------
module mfv_div #(
  parameter int DW = 16,
  parameter int QW = 39
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] divisor,
  input  logic [DW-1:0] rem_init,
  input  logic [QW-1:0] low,
  output logic [QW-1:0] quo
);

  logic [DW-1:0] rem [QW];
  logic [DW-1:0] dv  [QW];
  // dividend bits shift out the top while quotient bits shift in below
  logic [QW-1:0] lq  [QW];

  for (genvar i = 0; i < QW; i++) begin : g_step
    logic [DW-1:0] rem_in;
    logic [DW-1:0] dv_in;
    logic [QW-1:0] lq_in;
    logic [DW:0]   cur;
    logic [DW:0]   diff;
    logic          take;

    if (i == 0) begin : g_first
      assign rem_in = rem_init;
      assign dv_in  = divisor;
      assign lq_in  = low;
    end else begin : g_next
      assign rem_in = rem[i-1];
      assign dv_in  = dv[i-1];
      assign lq_in  = lq[i-1];
    end

    assign cur  = {rem_in, lq_in[QW-1]};
    assign diff = cur - (DW+1)'(dv_in);
    assign take = (cur >= (DW+1)'(dv_in));

    always_ff @(posedge clk) begin
      if (en) begin
        rem[i] <= take ? diff[DW-1:0] : cur[DW-1:0];
        dv[i]  <= dv_in;
        lq[i]  <= {lq_in[QW-2:0], take};
      end
    end
  end

  assign quo = lq[QW-1];

endmodule

// ----- hdl/mfv_mul_split.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity wide multiplier
// Two-stage product: two partial products of the split operand, then a sum.
// ----------------------------------------------------------------------------
module mfv_mul_split #(
  parameter int AW = 39,
  parameter int BW = 24
) (
  input  logic             clk,
  input  logic             en,
  input  logic [AW-1:0]    a,
  input  logic [BW-1:0]    b,
  output logic [AW+BW-1:0] p
);

  localparam int LW = AW / 2;
  localparam int HW = AW - LW;

  logic [LW+BW-1:0] plo;
  logic [HW+BW-1:0] phi;

  always_ff @(posedge clk) begin
    if (en) begin
      plo <= a[LW-1:0] * b;
      phi <= a[AW-1:LW] * b;
      p   <= {phi, {LW{1'b0}}} + (AW+BW)'(plo);
    end
  end

endmodule

// ----- hdl/manning_flow_velocity.sv -----
// ----------------------------------------------------------------------------
// Manning flow velocity
// Velocity, discharge and Froude number of open-channel flow, fully pipelined.
// ----------------------------------------------------------------------------
//  channel   direction  handshake          payload
//  s_axis    in         s_tvalid/s_tready  s_tdata: n, R, S, A, D
//  m_axis    out        m_tvalid/m_tready  m_tdata: V, Q, Fr, regime; m_tuser
//  cfg       in         cfg_we             cfg_wdata: us_units
//
//  One transaction per cycle while the output is not stalled.
//  Depth is set by the bit-serial stages: 24-bit square root of S, 39-bit
//  velocity divide and 32-bit Froude divide in series.
//  rst is synchronous; it clears the valid bits, the output and skid valid flags and the unit select.
//  A stalled output parks one result in the skid register, then freezes the
//  whole pipeline until it drains.
// ----------------------------------------------------------------------------
`include "manning_flow_velocity_macros.svh"

module manning_flow_velocity (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  // roughness[15:0], radius[39:16], slope[63:40], area[87:64], depth[111:88]
  input  logic [mfv_pkg::IN_TDATA_W-1:0]      s_tdata,
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // velocity[31:0], discharge[71:32], froude[103:72], flow_regime[105:104], zero
  output logic [mfv_pkg::OUT_TDATA_W-1:0]     m_tdata,
  // status[1:0], discharge_valid[2], froude_valid[3]
  output logic [mfv_pkg::OUT_TUSER_W-1:0]     m_tuser
);

  localparam int LAT = mfv_pkg::LAT;

  typedef struct packed {
    logic [mfv_pkg::K_W-1:0] k;
    logic [mfv_pkg::N_W-1:0] n;
    logic [mfv_pkg::A_W-1:0] a;
    logic                    anz;
    logic                    dnz;
    mfv_pkg::status_t        st;
  } sb1_t;

  typedef struct packed {
    logic [mfv_pkg::A_W-1:0] a;
    logic                    anz;
    logic                    dnz;
    mfv_pkg::status_t        st;
  } sb2_t;

  typedef struct packed {
    logic [mfv_pkg::VF_W-1:0] vf;
    logic                     ovf;
    mfv_pkg::regime_t         rg;
    logic                     anz;
    logic                     dnz;
    mfv_pkg::status_t         st;
  } sb3_t;

  logic           us_units;
  logic           en;
  logic           skid_valid;
  logic [LAT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      us_units <= 1'b0;
    end else if (cfg_we) begin
      us_units <= cfg_wdata;
    end
  end

  assign en       = !skid_valid;
  assign s_tready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-2:0], s_tvalid};
    end
  end

  // ---- stage 0: capture
  logic [mfv_pkg::N_W-1:0] n_in;
  logic [mfv_pkg::R_W-1:0] r_in;
  logic [mfv_pkg::S_W-1:0] s_in;
  mfv_pkg::status_t        st_in;

  assign n_in = s_tdata[15:0];
  assign r_in = s_tdata[39:16];
  assign s_in = s_tdata[63:40];

  always_comb begin
    priority if (n_in == '0) begin
      st_in = mfv_pkg::ST_N_ZERO;
    end else if (r_in == '0) begin
      st_in = mfv_pkg::ST_R_ZERO;
    end else if (s_in == '0) begin
      st_in = mfv_pkg::ST_S_ZERO;
    end else begin
      st_in = mfv_pkg::ST_OK;
    end
  end

  logic [mfv_pkg::N_W-1:0] n0;
  logic [mfv_pkg::R_W-1:0] r0;
  logic [mfv_pkg::S_W-1:0] s0;
  logic [mfv_pkg::A_W-1:0] a0;
  logic [mfv_pkg::D_W-1:0] d0;
  logic                    us0;
  logic                    anz0;
  logic                    dnz0;
  mfv_pkg::status_t        st0;

  always_ff @(posedge clk) begin
    if (en) begin
      n0   <= n_in;
      r0   <= r_in;
      s0   <= s_in;
      a0   <= s_tdata[87:64];
      d0   <= s_tdata[111:88];
      us0  <= us_units;
      anz0 <= (s_tdata[87:64] != '0);
      dnz0 <= (s_tdata[111:88] != '0);
      st0  <= st_in;
    end
  end

  // ---- stage 1: square R, form g*D
  logic [2*mfv_pkg::R_W-1:0]           rr1;
  logic [mfv_pkg::G_W+mfv_pkg::D_W-1:0] gd1;
  logic [mfv_pkg::S_W-1:0]             s1;
  sb1_t                                sb1;
  logic [mfv_pkg::G_W-1:0]             g0;

  assign g0 = us0 ? mfv_pkg::G_US : mfv_pkg::G_SI;

  always_ff @(posedge clk) begin
    if (en) begin
      rr1     <= r0 * r0;
      gd1     <= g0 * d0;
      s1      <= s0;
      sb1.k   <= us0 ? mfv_pkg::K_US : mfv_pkg::K_SI;
      sb1.n   <= n0;
      sb1.a   <= a0;
      sb1.anz <= anz0;
      sb1.dnz <= dnz0;
      sb1.st  <= st0;
    end
  end

  // ---- roots
  logic [mfv_pkg::SQS_W-1:0]  sqs;
  logic [mfv_pkg::R23_W-1:0]  r23;
  logic [mfv_pkg::R23_W-1:0]  r23_d;
  logic [mfv_pkg::SQGD_W-1:0] sqgd;
  logic [mfv_pkg::SQGD_W-1:0] sqgd_d;
  sb1_t                       sb1_d;

  mfv_isqrt #(.XW(48), .YW(mfv_pkg::SQS_W)) u_sqrt_s (
    .clk(clk), .en(en), .x({s1, 24'b0}), .y(sqs)
  );

  mfv_icbrt #(.XW(64), .YW(mfv_pkg::R23_W)) u_cbrt_r (
    .clk(clk), .en(en), .x({rr1, 16'b0}), .y(r23)
  );

  mfv_isqrt #(.XW(62), .YW(mfv_pkg::SQGD_W)) u_sqrt_gd (
    .clk(clk), .en(en), .x({gd1, 16'b0}), .y(sqgd)
  );

  mfv_delay #(.W(mfv_pkg::R23_W), .DEPTH(2)) u_dly_r23 (
    .clk(clk), .en(en), .din(r23), .dout(r23_d)
  );

  mfv_delay #(.W($bits(sb1_t)), .DEPTH(24)) u_dly_sb1 (
    .clk(clk), .en(en), .din(sb1), .dout(sb1_d)
  );

  mfv_delay #(.W(mfv_pkg::SQGD_W), .DEPTH(35)) u_dly_sqgd (
    .clk(clk), .en(en), .din(sqgd), .dout(sqgd_d)
  );

  // ---- stage 2: k * R^(2/3)
  logic [mfv_pkg::K_W+mfv_pkg::R23_W-1:0] p1;
  logic [mfv_pkg::SQS_W-1:0]              sqs2;
  logic [mfv_pkg::N_W-1:0]                n2;
  sb2_t                                   sb2;

  always_ff @(posedge clk) begin
    if (en) begin
      p1      <= sb1_d.k * r23_d;
      sqs2    <= sqs;
      n2      <= sb1_d.n;
      sb2.a   <= sb1_d.a;
      sb2.anz <= sb1_d.anz;
      sb2.dnz <= sb1_d.dnz;
      sb2.st  <= sb1_d.st;
    end
  end

  // ---- times sqrt(S), then divide by n
  logic [62:0]                prod1;
  logic [mfv_pkg::N_W-1:0]    n3;
  logic [mfv_pkg::VF_W-1:0]   vf;
  sb2_t                       sb2_d;

  mfv_mul_split #(.AW(mfv_pkg::K_W + mfv_pkg::R23_W), .BW(mfv_pkg::SQS_W)) u_mul_v (
    .clk(clk), .en(en), .a(p1), .b(sqs2), .p(prod1)
  );

  mfv_delay #(.W(mfv_pkg::N_W), .DEPTH(2)) u_dly_n (
    .clk(clk), .en(en), .din(n2), .dout(n3)
  );

  mfv_div #(.DW(mfv_pkg::N_W), .QW(mfv_pkg::VF_W)) u_div_v (
    .clk(clk), .en(en), .divisor(n3), .rem_init('0), .low(prod1[62:24]), .quo(vf)
  );

  mfv_delay #(.W($bits(sb2_t)), .DEPTH(41)) u_dly_sb2 (
    .clk(clk), .en(en), .din(sb2), .dout(sb2_d)
  );

  // ---- stage F: Froude overflow and regime
  logic [mfv_pkg::SQGD_W-1:0] sqgd5;
  logic [mfv_pkg::A_W-1:0]    a5;
  sb3_t                       sb3;
  mfv_pkg::regime_t           rg_c;
  logic [46:0]                lhs;

  assign lhs = {vf, 8'b0};

  always_comb begin
    priority if (lhs < 47'(sqgd_d)) begin
      rg_c = mfv_pkg::REG_SUB;
    end else if (lhs == 47'(sqgd_d)) begin
      rg_c = mfv_pkg::REG_CRIT;
    end else begin
      rg_c = mfv_pkg::REG_SUPER;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqgd5   <= sqgd_d;
      a5      <= sb2_d.a;
      sb3.vf  <= vf;
      sb3.ovf <= (vf[38:8] >= sqgd_d);
      sb3.rg  <= rg_c;
      sb3.anz <= sb2_d.anz;
      sb3.dnz <= sb2_d.dnz;
      sb3.st  <= sb2_d.st;
    end
  end

  // ---- Froude divide and discharge product
  logic [31:0] fq;
  logic [62:0] prod2;
  logic [62:0] prod2_d;
  sb3_t        sb3_d;

  mfv_div #(.DW(mfv_pkg::SQGD_W), .QW(32)) u_div_f (
    .clk(clk), .en(en), .divisor(sqgd5), .rem_init(sb3.vf[38:8]),
    .low({sb3.vf[7:0], 24'b0}), .quo(fq)
  );

  mfv_mul_split #(.AW(mfv_pkg::VF_W), .BW(mfv_pkg::A_W)) u_mul_q (
    .clk(clk), .en(en), .a(sb3.vf), .b(a5), .p(prod2)
  );

  mfv_delay #(.W(63), .DEPTH(30)) u_dly_q (
    .clk(clk), .en(en), .din(prod2), .dout(prod2_d)
  );

  mfv_delay #(.W($bits(sb3_t)), .DEPTH(32)) u_dly_sb3 (
    .clk(clk), .en(en), .din(sb3), .dout(sb3_d)
  );

  // ---- result stage: saturate and mask
  logic                               ok;
  logic                               dsc_ok;
  logic                               fr_ok;
  logic [31:0]                        vel_c;
  logic [39:0]                        dis_c;
  logic [31:0]                        fro_c;
  logic [54:0]                        q55;
  logic [mfv_pkg::OUT_TDATA_W-1:0]    p_tdata;
  logic [mfv_pkg::OUT_TUSER_W-1:0]    p_tuser;
  logic [mfv_pkg::OUT_TDATA_W-1:0]    skid_tdata;
  logic [mfv_pkg::OUT_TUSER_W-1:0]    skid_tuser;

  assign ok     = (sb3_d.st == mfv_pkg::ST_OK);
  assign dsc_ok = ok && sb3_d.anz;
  assign fr_ok  = ok && sb3_d.dnz;
  assign q55    = prod2_d[62:8];
  assign vel_c  = (|sb3_d.vf[38:32]) ? '1 : sb3_d.vf[31:0];
  assign dis_c  = (|q55[54:40]) ? '1 : q55[39:0];
  assign fro_c  = sb3_d.ovf ? '1 : fq;

  always_ff @(posedge clk) begin
    if (en) begin
      p_tdata <= {6'b0,
                  fr_ok ? sb3_d.rg : mfv_pkg::REG_SUB,
                  fr_ok ? fro_c : 32'd0,
                  dsc_ok ? dis_c : 40'd0,
                  ok ? vel_c : 32'd0};
      p_tuser <= {fr_ok, dsc_ok, sb3_d.st};
    end
  end

  // ---- output register with skid
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid   <= 1'b0;
      skid_valid <= 1'b0;
    end else if (!m_tvalid || m_tready) begin
      if (skid_valid) begin
        m_tvalid   <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        m_tvalid <= vld[LAT-1];
      end
    end else if (en && vld[LAT-1]) begin
      // output stalled: park the arriving result
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!m_tvalid || m_tready) begin
      m_tdata <= skid_valid ? skid_tdata : p_tdata;
      m_tuser <= skid_valid ? skid_tuser : p_tuser;
    end else if (en) begin
      skid_tdata <= p_tdata;
      skid_tuser <= p_tuser;
    end
  end

  `MFV_ASSERT_ALWAYS(a_reset_empty, rst |=> (!m_tvalid && !skid_valid), "output not empty after reset")
  `MFV_ASSERT(a_skid_behind_out, skid_valid |-> m_tvalid, "skid holds data with no output pending")
  `MFV_ASSERT(a_stall_freezes, skid_valid |=> $stable(vld), "pipeline advanced while skid full")
  `MFV_ASSERT(a_error_zero, (m_tvalid && (m_tuser[1:0] != mfv_pkg::ST_OK)) |-> (m_tdata[31:0] == 32'd0 && m_tuser[3:2] == 2'b00), "error result carries data")
  `MFV_ASSERT(a_froude_masked, (m_tvalid && !m_tuser[3]) |-> (m_tdata[105:72] == 34'd0), "froude fields set without depth")

endmodule

// ----- tb/sv/manning_flow_velocity_checker.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Manning flow velocity result checker
// Watches the input, output and unit-register traffic, predicts velocity,
// discharge, Froude number and regime for each input transaction and
// compares every output transaction against the oldest prediction.
// ----------------------------------------------------------------------------
module manning_flow_velocity_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic                                cfg_wdata,
  input  logic                                s_tvalid,
  input  logic                                s_tready,
  input  logic [mfv_pkg::IN_TDATA_W-1:0]      s_tdata,
  input  logic                                m_tvalid,
  input  logic                                m_tready,
  input  logic [mfv_pkg::OUT_TDATA_W-1:0]     m_tdata,
  input  logic [mfv_pkg::OUT_TUSER_W-1:0]     m_tuser,
  output int                                  errors,
  output int                                  pending,
  output int                                  flows_seen
);

  typedef struct packed {
    mfv_pkg::status_t status;
    logic [31:0]      velocity;
    logic [39:0]      discharge;
    logic             discharge_valid;
    logic [31:0]      froude;
    logic             froude_valid;
    mfv_pkg::regime_t regime;
  } flow_result_t;

  flow_result_t flow_q[$];
  logic         units_us;

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] r;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      logic [63:0] t;
      t = r | (64'd1 << b);
      if (t * t <= x) r = t;
    end
    return r;
  endfunction

  function automatic logic [63:0] int_cbrt(input logic [63:0] x);
    logic [63:0] y;
    y = 0;
    for (int b = 21; b >= 0; b--) begin
      logic [63:0] t;
      t = y | (64'd1 << b);
      if (t <= 64'd2642245 && t * t * t <= x) y = t;
    end
    return y;
  endfunction

  function automatic flow_result_t predict_flow(input logic [mfv_pkg::IN_TDATA_W-1:0] d,
                                                input logic us);
    flow_result_t o;
    logic [127:0] n, r, s, a, dp, k, g, sqs, r23, vf, q, sgd, f;
    o = '0;
    n = d[15:0]; r = d[39:16]; s = d[63:40]; a = d[87:64]; dp = d[111:88];
    if (n == 0) o.status = mfv_pkg::ST_N_ZERO;
    else if (r == 0) o.status = mfv_pkg::ST_R_ZERO;
    else if (s == 0) o.status = mfv_pkg::ST_S_ZERO;
    else begin
      o.status = mfv_pkg::ST_OK;
      k = us ? mfv_pkg::K_US : mfv_pkg::K_SI;
      g = us ? mfv_pkg::G_US : mfv_pkg::G_SI;
      sqs = int_sqrt(64'(s << 24));
      r23 = int_cbrt(64'((r * r) << 16));
      vf = (k * r23 * sqs) / (n << 24);
      o.velocity = vf > 128'hFFFFFFFF ? 32'hFFFFFFFF : vf[31:0];
      if (a != 0) begin
        q = (vf * a) >> 8;
        o.discharge = q > 128'hFFFFFFFFFF ? 40'hFFFFFFFFFF : q[39:0];
        o.discharge_valid = 1'b1;
      end
      if (dp != 0) begin
        sgd = int_sqrt(64'((g * dp) << 16));
        f = (vf << 24) / sgd;
        o.froude = f > 128'hFFFFFFFF ? 32'hFFFFFFFF : f[31:0];
        o.froude_valid = 1'b1;
        if ((vf << 8) < sgd) o.regime = mfv_pkg::REG_SUB;
        else if ((vf << 8) == sgd) o.regime = mfv_pkg::REG_CRIT;
        else o.regime = mfv_pkg::REG_SUPER;
      end
    end
    return o;
  endfunction

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h at %0t", what, got, want, $realtime);
    errors++;
  endtask

  assign pending = flow_q.size();

  always @(posedge clk) begin
    flow_result_t w;
    if (rst) begin
      units_us <= 1'b0;
    end else begin
      if (cfg_we) units_us <= cfg_wdata;
      if (s_tvalid && s_tready) flow_q.push_back(predict_flow(s_tdata, units_us));
      if (m_tvalid && m_tready) begin
        flows_seen++;
        if (flow_q.size() == 0) begin
          report_mismatch("unexpected result", m_tdata[63:0], 0);
        end else begin
          w = flow_q.pop_front();
          if (m_tuser[1:0] !== w.status) report_mismatch("status", m_tuser[1:0], w.status);
          if (m_tdata[31:0] !== w.velocity) report_mismatch("velocity", m_tdata[31:0], w.velocity);
          if (m_tdata[71:32] !== w.discharge)
            report_mismatch("discharge", m_tdata[71:32], w.discharge);
          if (m_tuser[2] !== w.discharge_valid)
            report_mismatch("discharge_valid", m_tuser[2], w.discharge_valid);
          if (m_tdata[103:72] !== w.froude) report_mismatch("froude", m_tdata[103:72], w.froude);
          if (m_tuser[3] !== w.froude_valid)
            report_mismatch("froude_valid", m_tuser[3], w.froude_valid);
          if (m_tdata[105:104] !== w.regime)
            report_mismatch("flow_regime", m_tdata[105:104], w.regime);
          if (m_tdata[111:106] !== '0) report_mismatch("pad bits", m_tdata[111:106], 0);
        end
      end
    end
  end
endmodule

// ----- tb/sv/manning_flow_velocity_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Manning flow velocity testbench
// Drives directed and random channel measurements in both unit systems with
// random gaps and output stalls; the checker compares every result.
// ----------------------------------------------------------------------------
module manning_flow_velocity_tb;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            cfg_we = 1'b0;
  logic                            cfg_wdata = 1'b0;
  logic                            s_tvalid = 1'b0;
  logic                            s_tready;
  logic [mfv_pkg::IN_TDATA_W-1:0]  s_tdata = '0;
  logic                            m_tvalid;
  logic                            m_tready = 1'b0;
  logic [mfv_pkg::OUT_TDATA_W-1:0] m_tdata;
  logic [mfv_pkg::OUT_TUSER_W-1:0] m_tuser;
  int                              errors, pending, flows_seen;
  int                              out_gap;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  manning_flow_velocity i_dut (.*);

  manning_flow_velocity_checker i_checker (.*);

  task automatic send_channel(input logic [15:0] n, input logic [23:0] r,
                              input logic [23:0] s, input logic [23:0] a, input logic [23:0] d);
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {d, a, s, r, n};
    do @(posedge clk); while (!s_tready);
  endtask

  function automatic logic [23:0] rand_field24();
    case ($urandom_range(0, 5))
      0: return 24'd0;
      1: return 24'hFFFFFF;
      2: return 24'($urandom_range(1, 255));
      3: return 24'($urandom_range(1, 65535));
      default: return 24'($urandom);
    endcase
  endfunction

  task automatic drain_and_set_units(input logic us);
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (mfv_pkg::LAT + 10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= us;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // output stall: draw a wait for every result
  always @(posedge clk) begin
    int gap;
    gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 14);
    if (rst) begin
      m_tready <= 1'b0;
      out_gap  <= 0;
    end else if (m_tvalid && m_tready) begin
      m_tready <= (gap == 0);
      out_gap  <= gap;
    end else if (!m_tready) begin
      m_tready <= (out_gap <= 1);
      out_gap  <= out_gap - 1;
    end
  end

  initial begin
    logic [15:0] n;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    for (int ph = 0; ph < 4; ph++) begin
      drain_and_set_units(ph[0]);
      // extremes and error cases
      send_channel(16'd0, 24'd5, 24'd5, 24'd5, 24'd5);
      send_channel(16'd0, 24'd0, 24'd0, 24'd0, 24'd0);
      send_channel(16'd1, 24'd0, 24'd0, 24'd9, 24'd9);
      send_channel(16'd1, 24'd1, 24'd0, 24'd9, 24'd9);
      send_channel(16'd1, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_channel(16'hFFFF, 24'd1, 24'd1, 24'd0, 24'd0);
      send_channel(16'hFFFF, 24'd1, 24'd1, 24'd1, 24'd1);
      send_channel(16'd2184, 24'd65536, 24'd16777, 24'd256, 24'd65536);
      send_channel(16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF);
      send_channel(16'd1, 24'd1, 24'd1, 24'd1, 24'hFFFFFF);
      for (int i = 0; i < 380; i++) begin
        n = ($urandom_range(0, 19) == 0) ? 16'd0 :
            ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(400, 5000));
        send_channel(n, ($urandom_range(0, 19) == 0) ? 24'd0 : rand_field24() | 24'd1,
                     ($urandom_range(0, 19) == 0) ? 24'd0 : rand_field24() | 24'd1,
                     rand_field24(), rand_field24());
      end
    end
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (mfv_pkg::LAT + 20) @(posedge clk);
    $display("ran %0d results over SI and US units with random gaps and stalls", flows_seen);
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("timeout");
    $display("status: fail");
    $finish;
  end
endmodule
